>>> rtl/kwdt_pkg.sv
// shared types, codes and constants of the keyed watchdog timer
// no dependencies; used by kwdt_step and keyed_watchdog_timer_core
package kwdt_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } kwdt_mode_e;

  typedef enum logic [1:0] {
    SEL_CTRL  = 2'd0,
    SEL_COUNT = 2'd1,
    SEL_RSTAT = 2'd2,
    SEL_NONE  = 2'd3
  } kwdt_sel_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_KEY   = 2'd1,
    ST_CTRL_BITS = 2'd2,
    ST_UNREAD    = 2'd3
  } kwdt_status_e;

  localparam logic [7:0] KeyCount     = 8'h5A;
  localparam logic [7:0] KeyCtrl      = 8'hA5;
  localparam logic [7:0] CtrlRequired = 8'h98;
  localparam logic [7:0] CtrlReadOr   = 8'h18;
  localparam logic [7:0] RstReadOr    = 8'h1F;
  localparam int unsigned CtrlEnaBit  = 5;
  localparam int unsigned CtrlWdtBit  = 6;
  localparam int unsigned RstEnaBit   = 6;
  localparam int unsigned PsW         = 17;

  typedef struct packed {
    logic [7:0]     ctrl;
    logic [7:0]     count;
    logic [PsW-1:0] pscale;
    logic           ovf;
    logic           rst_en;
    logic           flag_read;
  } kwdt_state_t;

  typedef struct packed {
    logic [7:0]   read_data;
    logic         interval_pulse;
    logic         reset_request;
    logic         overflow_flag;
    kwdt_status_e status;
  } kwdt_result_t;

  // prescaler divisor, one bit wider than the prescale count
  function automatic logic [PsW:0] divisor(input logic [2:0] sel);
    logic [PsW:0] d;
    unique case (sel)
      3'd0:    d = 18'd4;
      3'd1:    d = 18'd64;
      3'd2:    d = 18'd128;
      3'd3:    d = 18'd512;
      3'd4:    d = 18'd2048;
      3'd5:    d = 18'd8192;
      3'd6:    d = 18'd32768;
      default: d = 18'd131072;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/kwdt_step.sv
// next-state and result logic for one item of the keyed watchdog timer
// depends on kwdt_pkg
module kwdt_step (
  input  kwdt_pkg::kwdt_state_t  state_i,
  input  logic [1:0]             mode_i,
  input  logic [1:0]             reg_select_i,
  input  logic [15:0]            write_data_i,
  output kwdt_pkg::kwdt_state_t  state_o,
  output kwdt_pkg::kwdt_result_t result_o
);
  import kwdt_pkg::*;

  logic [7:0]   key;
  logic [7:0]   low;
  logic [PsW:0] ps_inc;
  logic         period_done;

  assign key         = write_data_i[15:8];
  assign low         = write_data_i[7:0];
  assign ps_inc      = {1'b0, state_i.pscale} + {{PsW{1'b0}}, 1'b1};
  assign period_done = ps_inc >= divisor(state_i.ctrl[2:0]);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.status = ST_OK;
    unique case (kwdt_mode_e'(mode_i))
      MODE_TICK: begin
        if (state_i.ctrl[CtrlEnaBit]) begin
          if (period_done) begin
            state_o.pscale = '0;
            state_o.count  = state_i.count + 8'd1;
            if (state_i.count == 8'hFF) begin
              if (state_i.ctrl[CtrlWdtBit]) begin
                state_o.ovf = 1'b1;
                result_o.reset_request = state_i.rst_en;
              end else begin
                result_o.interval_pulse = 1'b1;
              end
            end
          end else begin
            state_o.pscale = ps_inc[PsW-1:0];
          end
        end
      end
      MODE_READ: begin
        unique case (kwdt_sel_e'(reg_select_i))
          SEL_CTRL:  result_o.read_data = state_i.ctrl | CtrlReadOr;
          SEL_COUNT: result_o.read_data = state_i.count;
          SEL_RSTAT: begin
            if (state_i.ovf) state_o.flag_read = 1'b1;
            result_o.read_data = {state_i.ovf, state_i.rst_en, 6'd0} | RstReadOr;
          end
          default:   result_o.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (kwdt_sel_e'(reg_select_i))
          SEL_CTRL: begin
            priority if (key == KeyCount) begin
              state_o.count = low;
            end else if (key == KeyCtrl) begin
              state_o.ctrl = low;
              if ((low & CtrlRequired) != CtrlRequired) result_o.status = ST_CTRL_BITS;
            end else begin
              result_o.status = ST_BAD_KEY;
            end
          end
          SEL_RSTAT: begin
            priority if (key == KeyCtrl) begin
              // bit 0 set leaves the flag alone
              if (!low[0]) begin
                if (!state_i.flag_read) result_o.status = ST_UNREAD;
                state_o.flag_read = 1'b0;
                state_o.ovf       = 1'b0;
              end
            end else if (key == KeyCount) begin
              state_o.rst_en = low[RstEnaBit];
            end else begin
              result_o.status = ST_BAD_KEY;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    result_o.overflow_flag = state_o.ovf;
  end

endmodule

>>> rtl/keyed_watchdog_timer_core.sv
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: mode, reg_select; tdata: write_data
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: read_data, pulse, reset req, flag, status
//
// one item per cycle sustained while the output is not stalled; the result is offered
// from the result register after the item has passed the input register; the timer
// state and the result register update when the item fires, through one pass of kwdt_step
// rst_ni clears the timer state and both valid flags asynchronously
// a stalled output holds its result; the input register keeps taking items
// as long as the result register can move
module keyed_watchdog_timer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] write_data
  input  logic [3:0]  s_axis_tuser,   // [1:0] mode, [3:2] reg_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] interval_pulse,
                                      // [9] reset_request, [10] overflow_flag,
                                      // [12:11] status, [15:13] zero
);
  import kwdt_pkg::*;

  logic         in_valid_q;
  logic [1:0]   in_mode_q;
  logic [1:0]   in_sel_q;
  logic [15:0]  in_data_q;
  logic         out_valid_q;
  kwdt_result_t out_res_q;
  kwdt_state_t  state_q;
  kwdt_state_t  state_d;
  kwdt_result_t res_d;
  logic         fire;
  logic         in_take;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  kwdt_step u_step (
    .state_i      (state_q),
    .mode_i       (in_mode_q),
    .reg_select_i (in_sel_q),
    .write_data_i (in_data_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tuser[1:0];
      in_sel_q  <= s_axis_tuser[3:2];
      in_data_q <= s_axis_tdata;
    end
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.status, out_res_q.overflow_flag,
                          out_res_q.reset_request, out_res_q.interval_pulse,
                          out_res_q.read_data};

endmodule

>>> rtl/kwdt_checker.sv
// port-level checks on the keyed watchdog timer output stream
// bound to keyed_watchdog_timer_core; no package dependency
module kwdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a reset request only comes with the overflow flag set
  a_req_has_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> m_axis_tdata[10])
    else $error("reset request without overflow flag");

  // a wrap is either an interval pulse or a watchdog event, never both
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("interval pulse and reset request together");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

endmodule

bind keyed_watchdog_timer_core kwdt_checker u_kwdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
